@@ sv/fractal_escape_time_core_defines.svh @@
// Assertion macros used by the checker file of the escape-time core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FRACTAL_ESCAPE_TIME_CORE_DEFINES_SVH
`define FRACTAL_ESCAPE_TIME_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fet_pkg.sv @@
`timescale 1ns / 1ps

package fet_pkg;

  // Fixed field widths.
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int STEP_W     = 31;
  localparam int PIXEL_W    = 12;
  localparam int ITER_OUT_W = 14;
  localparam int MAG_W      = 34;
  localparam int CFG_IDX_W  = 3;

  // Defaults of the top-level parameters.
  localparam int ITER_LIMIT_DEF       = 8192;
  localparam int FRAC_BITS_DEF        = 28;
  localparam int COORD_BITS_DEF       = 12;
  localparam int ESCAPE_RADIUS_SQ_DEF = 4;

  // Register values after reset.
  localparam logic               MODE_RST        = 1'b0;
  localparam logic [DATA_W-1:0]  ORIGIN_RE_RST   = 32'hF800_0000;
  localparam logic [DATA_W-1:0]  ORIGIN_IM_RST   = 32'h0000_0000;
  localparam logic [STEP_W-1:0]  STEP_RST        = 31'h4000_0000;
  localparam logic [DATA_W-1:0]  JULIA_RE_RST    = 32'hF800_0000;
  localparam logic [DATA_W-1:0]  JULIA_IM_RST    = 32'h0000_0000;
  localparam logic [ITER_OUT_W-1:0] MAX_ITER_RST = 14'd8192;

  // Saturation bounds of a signed data word, held at product width.
  localparam logic signed [PROD_W-1:0] SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam logic signed [PROD_W-1:0] SAT_LO = -(64'sd1 <<< (DATA_W - 1));

  // Largest value of the magnitude output.
  localparam logic [PROD_W-1:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRACTAL_MODE = 3'd0,
    CFG_ORIGIN_REAL  = 3'd1,
    CFG_ORIGIN_IMAG  = 3'd2,
    CFG_PIXEL_STEP   = 3'd3,
    CFG_JULIA_REAL   = 3'd4,
    CFG_JULIA_IMAG   = 3'd5,
    CFG_MAX_ITER     = 3'd6
  } cfg_idx_t;

  // Pixel sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ADD,
    ST_DELIVER
  } fet_state_t;

  // Controls from the sequencer to the iteration datapath.
  typedef struct packed {
    logic load;
    logic mul_en;
    logic add_en;
  } iter_ctrl_t;

  // Clamp a wide signed value into the signed data word range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(DATA_W - 1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/fet_iter.sv @@
`timescale 1ns / 1ps

module fet_iter
  import fet_pkg::*;
#(
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int ESCAPE_RADIUS_SQ = ESCAPE_RADIUS_SQ_DEF
) (
  input  logic                     clk,
  input  iter_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] load_z_re,
  input  logic signed [DATA_W-1:0] load_z_im,
  input  logic signed [DATA_W-1:0] load_c_re,
  input  logic signed [DATA_W-1:0] load_c_im,
  output logic                     over,
  output logic [MAG_W-1:0]         mag_sq
);

  localparam logic [PROD_W-1:0] THR = PROD_W'(ESCAPE_RADIUS_SQ) << FRAC_BITS;

  logic signed [DATA_W-1:0] z_re_r, z_im_r, c_re_r, c_im_r;
  logic signed [PROD_W-1:0] rr_r, ii_r, ri_r;
  logic signed [DATA_W-1:0] z_re_nxt, z_im_nxt;
  logic signed [PROD_W-1:0] diff, re_sh, im_sh;
  logic [PROD_W-1:0]        sum_sq, mag_full;

  // Product stage: the two squares and the cross term of the current z.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      rr_r <= z_re_r * z_re_r;
      ii_r <= z_im_r * z_im_r;
      ri_r <= z_re_r * z_im_r;
    end
  end

  // Magnitude of the current z, taken from the stored squares.
  always_comb begin
    sum_sq   = $unsigned(rr_r) + $unsigned(ii_r);
    mag_full = sum_sq >> FRAC_BITS;
    over     = mag_full > THR;
    mag_sq   = (mag_full > MAG_MAX) ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];
  end

  // Next z: shifts round toward minus infinity, then c is added and clamped.
  always_comb begin
    diff     = rr_r - ii_r;
    re_sh    = diff >>> FRAC_BITS;
    im_sh    = ri_r >>> (FRAC_BITS - 1);
    z_re_nxt = sat32(re_sh + PROD_W'(c_re_r));
    z_im_nxt = sat32(im_sh + PROD_W'(c_im_r));
  end

  // z and c registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      z_re_r <= load_z_re;
      z_im_r <= load_z_im;
      c_re_r <= load_c_re;
      c_im_r <= load_c_im;
    end else if (ctrl.add_en) begin
      z_re_r <= z_re_nxt;
      z_im_r <= z_im_nxt;
    end
  end

endmodule

@@ sv/fet_hist.sv @@
`timescale 1ns / 1ps

module fet_hist
  import fet_pkg::*;
#(
  parameter int  DEPTH = ITER_LIMIT_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hist_req,
  input  logic [AW-1:0] hist_bin,
  output logic          hist_busy
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              upd_r;
  logic [AW-1:0]     upd_bin_r;
  logic [DATA_W-1:0] esc_total_r;

  assign hist_busy = clr_busy_r;

  // Clearing sweep after reset, one bin per cycle.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // A request reads its bin now and writes back the increment next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
    end else begin
      upd_r <= hist_req && !clr_busy_r;
    end
    upd_bin_r <= hist_bin;
  end

  // Bin memory with a registered read port.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (upd_r) begin
      mem[upd_bin_r] <= rd_data_r + DATA_W'(1);
    end
    rd_data_r <= mem[hist_bin];
  end

  // Running total of escaped pixels; wraps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_total_r <= '0;
    end else if (hist_req) begin
      esc_total_r <= esc_total_r + DATA_W'(1);
    end
  end

endmodule

@@ sv/fractal_escape_time_core.sv @@
`timescale 1ns / 1ps

// Escape-time pixel engine for Mandelbrot and Julia images. Each input transfer
// names one pixel; the block maps it to a complex point in signed Q4.28, runs
// z = z*z + c until |z|^2 passes the escape radius or max_iter iterations are
// done, and returns one result transfer with the iteration count, the escape
// flag and the last |z|^2. One pixel is in work at a time. A pixel passes a
// mapping step, then a multiply step and an add step for each iteration plus
// one final check, and a delivery step that hands the result to the output
// register, which can still hold an earlier result while the next pixel runs;
// delivery waits while a stalled result is still held there. Escapes are
// counted in a bin memory of ITER_LIMIT entries; after reset the block sweeps
// that memory to zero and holds in_stall high meanwhile.
// Configuration registers should be written only while the block is idle.
module fractal_escape_time_core
  import fet_pkg::*;
#(
  parameter int ITER_LIMIT       = ITER_LIMIT_DEF,
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int ESCAPE_RADIUS_SQ = ESCAPE_RADIUS_SQ_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_W-1:0]    in_pixel_x,
  input  logic [PIXEL_W-1:0]    in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ITER_OUT_W-1:0] out_iterations,
  output logic                  out_escaped,
  output logic [MAG_W-1:0]      out_magnitude_sq,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data
);

  localparam int CNT_W   = $clog2(ITER_LIMIT + 1);
  localparam int HIST_AW = $clog2(ITER_LIMIT);
  localparam int MAP_W   = PIXEL_W + STEP_W;
  localparam logic [PIXEL_W-1:0] CMASK =
    (COORD_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} : PIXEL_W'((1 << COORD_BITS) - 1);

  // Configuration registers.
  logic                     mode_r;
  logic signed [DATA_W-1:0] origin_re_r, origin_im_r, julia_re_r, julia_im_r;
  logic [STEP_W-1:0]        step_r;
  logic [ITER_OUT_W-1:0]    max_iter_r;

  // Sequencer and result registers.
  fet_state_t               state_r, state_nxt;
  logic [PIXEL_W-1:0]       px_r, py_r;
  logic [CNT_W-1:0]         cnt_r, limit_r, limit_nxt, bin_tmp;
  logic                     res_esc_r;
  logic [MAG_W-1:0]         res_mag_r;
  logic [CNT_W-1:0]         res_cnt_r;
  logic                     out_valid_r;
  logic [ITER_OUT_W-1:0]    out_iter_r;
  logic                     out_esc_r;
  logic [MAG_W-1:0]         out_mag_r;

  // Control between sequencer and units.
  iter_ctrl_t               ictrl;
  logic                     res_load, res_esc_nxt, cnt_inc, out_load, hist_req;
  logic                     hist_busy, iter_over;
  logic [MAG_W-1:0]         iter_mag;
  logic [HIST_AW-1:0]       hist_bin;

  // Pixel mapping.
  logic [MAP_W-1:0]         x_off, y_off;
  logic signed [DATA_W-1:0] p_re, p_im;
  logic signed [DATA_W-1:0] z0_re, z0_im, c0_re, c0_im;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RST;
      origin_re_r <= ORIGIN_RE_RST;
      origin_im_r <= ORIGIN_IM_RST;
      step_r      <= STEP_RST;
      julia_re_r  <= JULIA_RE_RST;
      julia_im_r  <= JULIA_IM_RST;
      max_iter_r  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRACTAL_MODE: mode_r      <= cfg_data[0];
        CFG_ORIGIN_REAL:  origin_re_r <= cfg_data;
        CFG_ORIGIN_IMAG:  origin_im_r <= cfg_data;
        CFG_PIXEL_STEP:   step_r      <= cfg_data[STEP_W-1:0];
        CFG_JULIA_REAL:   julia_re_r  <= cfg_data;
        CFG_JULIA_IMAG:   julia_im_r  <= cfg_data;
        CFG_MAX_ITER:     max_iter_r  <= cfg_data[ITER_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Map the pixel to a point; the row axis points down the image.
  always_comb begin
    x_off = px_r * step_r;
    y_off = py_r * step_r;
    p_re  = sat32(PROD_W'(origin_re_r) + $signed(PROD_W'(x_off)));
    p_im  = sat32(PROD_W'(origin_im_r) - $signed(PROD_W'(y_off)));
    if (mode_r) begin
      z0_re = p_re;
      z0_im = p_im;
      c0_re = julia_re_r;
      c0_im = julia_im_r;
    end else begin
      z0_re = '0;
      z0_im = '0;
      c0_re = p_re;
      c0_im = p_im;
    end
    limit_nxt = (32'(max_iter_r) > ITER_LIMIT) ? CNT_W'(ITER_LIMIT) : CNT_W'(max_iter_r);
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt   = state_r;
    ictrl       = '0;
    res_load    = 1'b0;
    res_esc_nxt = 1'b0;
    cnt_inc     = 1'b0;
    out_load    = 1'b0;
    hist_req    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        ictrl.load = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        ictrl.mul_en = 1'b1;
        state_nxt    = ST_ADD;
      end
      ST_ADD: begin
        if (cnt_r != '0 && iter_over) begin
          res_load    = 1'b1;
          res_esc_nxt = 1'b1;
          hist_req    = 1'b1;
          state_nxt   = ST_DELIVER;
        end else if (cnt_r == limit_r) begin
          res_load  = 1'b1;
          state_nxt = ST_DELIVER;
        end else begin
          ictrl.add_en = 1'b1;
          cnt_inc      = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE) || hist_busy;

  // Escapes on iteration n land in bin n - 1.
  assign bin_tmp  = cnt_r - CNT_W'(1);
  assign hist_bin = bin_tmp[HIST_AW-1:0];

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ictrl.load) begin
        cnt_r   <= '0;
        limit_r <= limit_nxt;
      end else if (cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Pixel capture and per-pixel result.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      px_r <= in_pixel_x & CMASK;
      py_r <= in_pixel_y & CMASK;
    end
    if (res_load) begin
      res_cnt_r <= cnt_r;
      res_esc_r <= res_esc_nxt;
      res_mag_r <= (cnt_r == '0) ? '0 : iter_mag;
    end
  end

  // Output register; it holds while the result transfer is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_iter_r <= ITER_OUT_W'(res_cnt_r);
      out_esc_r  <= res_esc_r;
      out_mag_r  <= res_mag_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_iterations   = out_iter_r;
  assign out_escaped      = out_esc_r;
  assign out_magnitude_sq = out_mag_r;

  fet_iter #(
    .FRAC_BITS       (FRAC_BITS),
    .ESCAPE_RADIUS_SQ(ESCAPE_RADIUS_SQ)
  ) u_iter (
    .clk      (clk),
    .ctrl     (ictrl),
    .load_z_re(z0_re),
    .load_z_im(z0_im),
    .load_c_re(c0_re),
    .load_c_im(c0_im),
    .over     (iter_over),
    .mag_sq   (iter_mag)
  );

  fet_hist #(
    .DEPTH(ITER_LIMIT)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .hist_req (hist_req),
    .hist_bin (hist_bin),
    .hist_busy(hist_busy)
  );

endmodule

@@ sv/fet_checker.sv @@
`timescale 1ns / 1ps
`include "fractal_escape_time_core_defines.svh"

module fet_checker
  import fet_pkg::*;
#(
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int ESCAPE_RADIUS_SQ = ESCAPE_RADIUS_SQ_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ITER_OUT_W-1:0] out_iterations,
  input logic                  out_escaped,
  input logic [MAG_W-1:0]      out_magnitude_sq
);

  localparam logic [PROD_W-1:0] THR = PROD_W'(ESCAPE_RADIUS_SQ) << FRAC_BITS;

  // A stalled result stays offered and unchanged.
  `FET_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `FET_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_iterations) && $stable(out_escaped) && $stable(out_magnitude_sq), "stalled result changed")

  // Only one pixel is in work: a transfer closes the input side next cycle.
  `FET_ASSERT_NEXT(a_one_pixel, in_valid && !in_stall, in_stall, "input open after transfer")

  // An escape needs at least one iteration and a magnitude past the radius.
  `FET_ASSERT_SAME(a_esc_iter, out_valid && out_escaped, out_iterations != '0, "escape without iteration")
  `FET_ASSERT_SAME(a_esc_mag, out_valid && out_escaped, (PROD_W'(out_magnitude_sq) > THR) || (&out_magnitude_sq), "escape below radius")

endmodule

bind fractal_escape_time_core fet_checker #(
  .FRAC_BITS       (FRAC_BITS),
  .ESCAPE_RADIUS_SQ(ESCAPE_RADIUS_SQ)
) u_fet_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_iterations  (out_iterations),
  .out_escaped     (out_escaped),
  .out_magnitude_sq(out_magnitude_sq)
);
